[rtl/assert_macros.svh]
// assertion macros shared by the glyph rasterizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SRG_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SRG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/srg_pkg.sv]
// types, constants and the font rom of the glyph rasterizer
package srg_pkg;

    localparam int COORD_BITS    = 12;
    localparam int POS_BITS      = COORD_BITS + 2;
    localparam int SCREEN_BITS   = 13;
    localparam int CODE_BITS     = 8;
    localparam int SCALE_BITS    = 4;
    localparam int COLOR_BITS    = 32;
    localparam int GLYPH_COLUMNS = 5;
    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_DOTS    = GLYPH_COLUMNS * GLYPH_ROWS;
    localparam int GLYPH_COUNT   = 95;
    localparam int GLYPH_IDX_BITS = $clog2(GLYPH_COUNT);
    localparam int COL_BITS      = $clog2(GLYPH_COLUMNS);
    localparam int ROW_BITS      = $clog2(GLYPH_ROWS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [CODE_BITS-1:0]   FIRST_CODE = 8'd32;
    localparam logic [CODE_BITS-1:0]   LAST_CODE  = 8'd126;
    localparam logic [7:0]             GLYPH_MASK = 8'h7F;
    localparam logic [SCREEN_BITS-1:0] SCREEN_W_RESET = 13'd1280;
    localparam logic [SCREEN_BITS-1:0] SCREEN_H_RESET = 13'd800;
    localparam logic [POS_BITS-1:0]    COORD_SPACE = POS_BITS'(1) << COORD_BITS;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SCREEN_W = 1'b0,
        CFG_SCREEN_H = 1'b1
    } t_cfg_idx;

    // one character as handed from the front to the dot scanner
    typedef struct packed {
        logic                  draw;
        logic [GLYPH_DOTS-1:0] glyph;
        logic [COORD_BITS-1:0] ox;
        logic [COORD_BITS-1:0] oy;
        logic [COLOR_BITS-1:0] color;
        logic [SCALE_BITS-1:0] scale;
    } t_job;

    // one emitted square
    typedef struct packed {
        logic                  visible;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [SCALE_BITS-1:0] w;
        logic [SCALE_BITS-1:0] h;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } t_result;

    // font rom, column bytes 0..4 from the high byte down
    localparam logic [39:0] GLYPH_ROM [0:GLYPH_COUNT-1] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08
    };

    // dot mask of a character, bit col*rows+row, zero outside the font
    function automatic logic [GLYPH_DOTS-1:0] glyph_bits(input logic [CODE_BITS-1:0] code);
        logic [39:0]                 entry;
        logic [7:0]                  col_byte;
        logic [GLYPH_DOTS-1:0]       bits;
        logic [GLYPH_IDX_BITS-1:0]   idx;
        bits = '0;
        idx  = GLYPH_IDX_BITS'(code - FIRST_CODE);
        if (code >= FIRST_CODE && code <= LAST_CODE) begin
            entry = GLYPH_ROM[idx];
            for (int c = 0; c < GLYPH_COLUMNS; c++) begin
                col_byte = entry[(GLYPH_COLUMNS - 1 - c) * 8 +: 8] & GLYPH_MASK;
                bits[c * GLYPH_ROWS +: GLYPH_ROWS] = col_byte[GLYPH_ROWS-1:0];
            end
        end
        return bits;
    endfunction

endpackage

[rtl/srg_item_if.sv]
// character input channel
interface srg_item_if;
    import srg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CODE_BITS-1:0]  char_code;
    logic [COORD_BITS-1:0] origin_x;
    logic [COORD_BITS-1:0] origin_y;
    logic [COLOR_BITS-1:0] ink_color;
    logic [SCALE_BITS-1:0] dot_scale;

    modport source (output valid, char_code, origin_x, origin_y, ink_color, dot_scale,
                    input ready);
    modport sink (input valid, char_code, origin_x, origin_y, ink_color, dot_scale,
                  output ready);
endinterface

[rtl/srg_result_if.sv]
// square output channel
interface srg_result_if;
    import srg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  visible;
    logic [COORD_BITS-1:0] square_x;
    logic [COORD_BITS-1:0] square_y;
    logic [SCALE_BITS-1:0] square_w;
    logic [SCALE_BITS-1:0] square_h;
    logic [COLOR_BITS-1:0] square_color;
    logic                  last;

    modport source (output valid, visible, square_x, square_y, square_w, square_h,
                    square_color, last, input ready);
    modport sink (input valid, visible, square_x, square_y, square_w, square_h,
                  square_color, last, output ready);
endinterface

[rtl/srg_front.sv]
// front: takes characters, classifies them and fetches the glyph
module srg_front (
    srg_item_if.sink       i_item,
    input  logic           i_queue_full,
    output logic           o_push,
    output srg_pkg::t_job  o_job
);
    import srg_pkg::*;

    logic in_range;

    // transfer whenever the queue has room
    assign i_item.ready = !i_queue_full;
    assign o_push       = i_item.valid && !i_queue_full;

    // printable code with a nonzero scale draws, anything else gives the empty result
    assign in_range = (i_item.char_code >= FIRST_CODE) && (i_item.char_code <= LAST_CODE);

    always_comb begin
        o_job.draw  = in_range && (i_item.dot_scale != '0);
        o_job.glyph = glyph_bits(i_item.char_code);
        o_job.ox    = i_item.origin_x;
        o_job.oy    = i_item.origin_y;
        o_job.color = i_item.ink_color;
        o_job.scale = i_item.dot_scale;
    end
endmodule

[rtl/srg_queue.sv]
// short job queue between front and dot scanner
`include "assert_macros.svh"

module srg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srg_pkg::t_job  i_push_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output srg_pkg::t_job  o_pop_job
);
    import srg_pkg::*;

    t_job                 r_slot [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QCNT_BITS-1:0] r_count;

    assign o_full    = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_pop_job = r_slot[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_push_job;
        end
    end

    `SRG_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "queue overflow")
    `SRG_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "queue underflow")
    `SRG_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, i_push && !i_pop && !o_valid, o_valid, "push lost")
endmodule

[rtl/srg_back.sv]
// back: scans 35 glyph dots, one per cycle but for stalls, and emits clipped squares
`include "assert_macros.svh"

module srg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  srg_pkg::t_job                 i_job,
    output logic                          o_job_pop,
    input  logic [srg_pkg::POS_BITS-1:0]  i_wlim,
    input  logic [srg_pkg::POS_BITS-1:0]  i_hlim,
    srg_result_if.source                  o_result
);
    import srg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    localparam logic [COL_BITS-1:0] LAST_COL = COL_BITS'(GLYPH_COLUMNS - 1);
    localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(GLYPH_ROWS - 1);
    localparam t_result             EMPTY_RESULT = '{1'b0, '0, '0, '0, '0, '0, 1'b1};

    t_state                r_state;
    t_state                n_state;
    logic                  r_have;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [COL_BITS-1:0]   r_col;
    logic [ROW_BITS-1:0]   r_row;
    logic [GLYPH_DOTS-1:0] r_bits;
    logic [POS_BITS-1:0]   r_sx;
    logic [POS_BITS-1:0]   r_sy;
    logic [COORD_BITS-1:0] r_oy;
    logic [COLOR_BITS-1:0] r_color;
    logic [SCALE_BITS-1:0] r_scale;
    t_result               r_hold;
    t_result               r_out;

    logic                  out_free;
    logic                  dot_vis;
    logic                  last_dot;
    logic                  scan_stall;
    logic [POS_BITS-1:0]   room_x;
    logic [POS_BITS-1:0]   room_y;
    t_result               cand;
    t_result               hold_last;

    assign out_free  = !r_out_valid || o_result.ready;
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    // current dot: lit and starting on screen
    assign dot_vis  = r_bits[0] && (r_sx < i_wlim) && (r_sy < i_hlim);
    assign last_dot = (r_col == LAST_COL) && (r_row == LAST_ROW);
    // a second visible dot needs the output register to take the held one
    assign scan_stall = (r_state == S_SCAN) && dot_vis && r_have && !out_free;

    // clipping against the screen limits
    assign room_x = i_wlim - r_sx;
    assign room_y = i_hlim - r_sy;

    always_comb begin
        cand.visible = 1'b1;
        cand.x       = r_sx[COORD_BITS-1:0];
        cand.y       = r_sy[COORD_BITS-1:0];
        cand.w       = (room_x < POS_BITS'(r_scale)) ? room_x[SCALE_BITS-1:0] : r_scale;
        cand.h       = (room_y < POS_BITS'(r_scale)) ? room_y[SCALE_BITS-1:0] : r_scale;
        cand.color   = r_color;
        cand.last    = 1'b0;
        hold_last      = r_hold;
        hold_last.last = 1'b1;
    end

    // output register occupancy
    always_comb begin
        n_out_valid = r_out_valid && !o_result.ready;
        if ((r_state == S_SCAN) && !scan_stall && dot_vis && r_have) begin
            n_out_valid = 1'b1;
        end
        if ((r_state == S_FLUSH) && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.draw ? S_SCAN : S_FLUSH;
                end
            end
            S_SCAN: begin
                if (!scan_stall && last_dot) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_have <= 1'b0;
                end
                S_SCAN: begin
                    if (!scan_stall) begin
                        if (dot_vis) begin
                            r_have <= 1'b1;
                        end
                        if (r_row == LAST_ROW) begin
                            r_row <= '0;
                            r_col <= r_col + 1'b1;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_have <= 1'b0;
                    end
                end
                default: r_have <= 1'b0;
            endcase
        end
    end

    // dot walk, held square and output payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    r_bits  <= i_job.glyph;
                    r_sx    <= POS_BITS'(i_job.ox);
                    r_sy    <= POS_BITS'(i_job.oy);
                    r_oy    <= i_job.oy;
                    r_color <= i_job.color;
                    r_scale <= i_job.scale;
                end
            end
            S_SCAN: begin
                if (!scan_stall) begin
                    if (dot_vis) begin
                        r_hold <= cand;
                        if (r_have) begin
                            r_out <= r_hold;
                        end
                    end
                    r_bits <= r_bits >> 1;
                    if (r_row == LAST_ROW) begin
                        r_sy <= POS_BITS'(r_oy);
                        r_sx <= r_sx + POS_BITS'(r_scale);
                    end else begin
                        r_sy <= r_sy + POS_BITS'(r_scale);
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    r_out <= r_have ? hold_last : EMPTY_RESULT;
                end
            end
            default: r_bits <= '0;
        endcase
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.visible      = r_out.visible;
    assign o_result.square_x     = r_out.x;
    assign o_result.square_y     = r_out.y;
    assign o_result.square_w     = r_out.w;
    assign o_result.square_h     = r_out.h;
    assign o_result.square_color = r_out.color;
    assign o_result.last         = r_out.last;

    `SRG_ASSERT_IMPLY(a_idle_no_hold, i_clk, i_rst_n, r_state == S_IDLE, !r_have, "square held while idle")
    `SRG_ASSERT_IMPLY(a_empty_is_last, i_clk, i_rst_n, r_out_valid && !r_out.visible, r_out.last, "empty result not last")
endmodule

[rtl/scaled_glyph_rasterizer_unit.sv]
// top level of the scaled 5x7 glyph rasterizer
// In the dot scanner a character is first loaded as a job, then all 35 glyph dots are walked
// column by column, top row first, and it closes with the last square; a stalled consumer
// can hold off both the scan and that last square. The back part has a single dot scanner;
// a two-entry job queue lets the front take further characters while one is being scanned.
// Each lit dot on screen gives one square clipped to the screen size; a character with nothing
// visible gives a single empty result marked last. The user must write screen width and height
// through the configuration port only while no character is in flight; it is not enforced.
module scaled_glyph_rasterizer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [srg_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [srg_pkg::SCREEN_BITS-1:0]   i_cfg_data,
    srg_item_if.sink                          i_item,
    srg_result_if.source                      o_result
);
    import srg_pkg::*;

    logic [SCREEN_BITS-1:0] r_screen_w;
    logic [SCREEN_BITS-1:0] r_screen_h;
    logic [POS_BITS-1:0]    wlim;
    logic [POS_BITS-1:0]    hlim;
    logic                   push;
    logic                   queue_full;
    logic                   job_valid;
    logic                   job_pop;
    t_job                   front_job;
    t_job                   back_job;

    // screen size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= SCREEN_W_RESET;
            r_screen_h <= SCREEN_H_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SCREEN_W: r_screen_w <= i_cfg_data;
                CFG_SCREEN_H: r_screen_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // limits capped to the coordinate space
    assign wlim = (POS_BITS'(r_screen_w) > COORD_SPACE) ? COORD_SPACE : POS_BITS'(r_screen_w);
    assign hlim = (POS_BITS'(r_screen_h) > COORD_SPACE) ? COORD_SPACE : POS_BITS'(r_screen_h);

    srg_front u_front (
        .i_item       (i_item),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (front_job)
    );

    srg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (front_job),
        .o_full     (queue_full),
        .i_pop      (job_pop),
        .o_valid    (job_valid),
        .o_pop_job  (back_job)
    );

    srg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (back_job),
        .o_job_pop   (job_pop),
        .i_wlim      (wlim),
        .i_hlim      (hlim),
        .o_result    (o_result)
    );
endmodule
